// ===== src/sha256_message_hasher_core_macros.svh =====
// assertion macros used by the sha-256 hasher rtl controller
// expects i_clk and i_rst_n in the scope of each use
`ifndef SHA256_MESSAGE_HASHER_CORE_MACROS_SVH
`define SHA256_MESSAGE_HASHER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define SMH_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SMH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sha256mh_pkg.sv =====
// shared types, constants and round functions of the sha-256 hasher
// no dependencies
package sha256mh_pkg;

    // source of the word pushed into the block window
    localparam logic [2:0] PUSH_IN     = 3'd0;
    localparam logic [2:0] PUSH_PAD80  = 3'd1;
    localparam logic [2:0] PUSH_ZERO   = 3'd2;
    localparam logic [2:0] PUSH_LEN_HI = 3'd3;
    localparam logic [2:0] PUSH_LEN_LO = 3'd4;

    localparam int unsigned ROUNDS = 64;

    localparam logic [31:0] HASH_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // commands from the controller to the datapath
    typedef struct packed {
        logic       take_input;
        logic       push;
        logic [2:0] push_sel;
        logic       load_vars;
        logic       round;
        logic [5:0] round_idx;
        logic       update;
        logic       digest;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_status;

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    // last word: keep the valid leading bytes, then the 0x80 pad byte; a full word is kept whole
    function automatic logic [31:0] fmt_last_word(input logic [31:0] w,
                                                  input logic [2:0]  nbytes);
        logic [31:0] r;
        case (nbytes)
            3'd0:    r = 32'h8000_0000;
            3'd1:    r = {w[31:24], 24'h80_0000};
            3'd2:    r = {w[31:16], 16'h8000};
            3'd3:    r = {w[31:8], 8'h80};
            default: r = w;
        endcase
        return r;
    endfunction

endpackage

// ===== src/sha256mh_if.sv =====
// valid/ready channel interfaces for message words and digest words
// no dependencies
interface sha256mh_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] message_word;
    logic [2:0]  valid_bytes;
    logic        end_of_message;

    modport source (output valid, output message_word, output valid_bytes,
                    output end_of_message, input ready);
    modport sink   (input valid, input message_word, input valid_bytes,
                    input end_of_message, output ready);
endinterface

interface sha256mh_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        final_word;

    modport source (output valid, output digest_word, output word_index,
                    output final_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input final_word, output ready);
endinterface

// ===== src/sha256mh_ctrl.sv =====
// controller of the sha-256 hasher: input acceptance, padding sequence, rounds
// depends on sha256mh_pkg and sha256_message_hasher_core_macros.svh
`include "sha256_message_hasher_core_macros.svh"

module sha256mh_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_last,
    input  logic [2:0]              i_nbytes,
    output logic                    o_in_ready,
    output sha256mh_pkg::t_dp_cmd    o_cmd,
    input  sha256mh_pkg::t_dp_status i_status
);
    import sha256mh_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PAD    = 3'd1;
    localparam logic [2:0] S_LEN_LO = 3'd2;
    localparam logic [2:0] S_ROUND  = 3'd3;
    localparam logic [2:0] S_UPDATE = 3'd4;
    localparam logic [2:0] S_DIGEST = 3'd5;

    logic [2:0] r_state, n_state;
    logic [2:0] r_ret, n_ret;
    logic [3:0] r_wib, n_wib;
    logic [5:0] r_rnd, n_rnd;
    logic       r_need80, n_need80;
    logic [2:0] push_next;
    logic       do_push;

    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_wib     = r_wib;
        n_rnd     = r_rnd;
        n_need80  = r_need80;
        o_cmd     = '0;
        push_next = r_state;
        do_push   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take_input = 1'b1;
                    o_cmd.push       = 1'b1;
                    o_cmd.push_sel   = PUSH_IN;
                    do_push          = 1'b1;
                    if (i_last) begin
                        push_next = S_PAD;
                        n_need80  = (i_nbytes >= 3'd4);
                    end else begin
                        push_next = S_IDLE;
                    end
                end
            end
            S_PAD: begin
                o_cmd.push = 1'b1;
                do_push    = 1'b1;
                push_next  = S_PAD;
                if (r_need80) begin
                    o_cmd.push_sel = PUSH_PAD80;
                    n_need80       = 1'b0;
                end else if (r_wib == 4'd14) begin
                    o_cmd.push_sel = PUSH_LEN_HI;
                    push_next      = S_LEN_LO;
                end else begin
                    o_cmd.push_sel = PUSH_ZERO;
                end
            end
            S_LEN_LO: begin
                o_cmd.push     = 1'b1;
                o_cmd.push_sel = PUSH_LEN_LO;
                do_push        = 1'b1;
                push_next      = S_DIGEST;
            end
            S_ROUND: begin
                o_cmd.round     = 1'b1;
                o_cmd.round_idx = r_rnd;
                n_rnd           = 6'(r_rnd + 6'd1);
                if (r_rnd == 6'(ROUNDS - 1)) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = r_ret;
            end
            S_DIGEST: begin
                if (!i_status.out_busy) begin
                    o_cmd.digest = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // the sixteenth word of a block starts the compression
        if (do_push) begin
            if (r_wib == 4'd15) begin
                n_wib           = '0;
                n_rnd           = '0;
                n_ret           = push_next;
                o_cmd.load_vars = 1'b1;
                n_state         = S_ROUND;
            end else begin
                n_wib   = 4'(r_wib + 4'd1);
                n_state = push_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_wib    <= '0;
            r_rnd    <= '0;
            r_need80 <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_wib    <= n_wib;
            r_rnd    <= n_rnd;
            r_need80 <= n_need80;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    `SMH_ASSERT_NEXT(a_round_end, (r_state == S_ROUND) && (r_rnd == 6'd63), r_state == S_UPDATE, "rounds did not end in update")
    `SMH_ASSERT_IMPLIES(a_round_block_empty, r_state == S_ROUND, r_wib == 4'd0, "block count not cleared during rounds")
    `SMH_ASSERT_IMPLIES(a_load_on_full, o_cmd.load_vars, o_cmd.push && (r_wib == 4'd15), "compression started on a partial block")
    `SMH_ASSERT_IMPLIES(a_digest_out_free, o_cmd.digest, !i_status.out_busy, "digest copied over an undrained digest")
    `SMH_ASSERT_NEXT(a_last_leaves_idle, i_in_valid && o_in_ready && i_last, r_state != S_IDLE, "last word did not start padding")

endmodule

// ===== src/sha256mh_dp.sv =====
// datapath of the sha-256 hasher: block window, round logic, chaining hash,
// bit count and digest output register; depends on sha256mh_pkg, sha256mh_if
module sha256mh_dp (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  sha256mh_pkg::t_dp_cmd     i_cmd,
    output sha256mh_pkg::t_dp_status  o_status,
    input  logic [31:0]              i_word,
    input  logic [2:0]               i_nbytes,
    input  logic                     i_last,
    sha256mh_out_if.source           o_dig
);
    import sha256mh_pkg::*;

    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [31:0] r_h [8];
    logic [63:0] r_bits;
    logic [31:0] r_out [8];
    logic [2:0]  r_out_idx;
    logic        r_out_valid;

    logic [31:0] push_word;
    logic [31:0] sched_word;
    logic [31:0] shift_in;
    logic [31:0] t1, t2;
    logic [5:0]  byte_bits;
    logic [2:0]  nbytes_sat;
    logic        out_take;

    always_comb begin
        case (i_cmd.push_sel)
            PUSH_IN:     push_word = i_last ? fmt_last_word(i_word, i_nbytes) : i_word;
            PUSH_PAD80:  push_word = 32'h8000_0000;
            PUSH_LEN_HI: push_word = r_bits[63:32];
            PUSH_LEN_LO: push_word = r_bits[31:0];
            default:     push_word = '0;
        endcase
    end

    // message schedule: the window holds w[t] .. w[t+15]
    assign sched_word = small_sigma1(r_w[14]) + r_w[9] + small_sigma0(r_w[1]) + r_w[0];
    assign shift_in   = i_cmd.round ? sched_word : push_word;

    assign t1 = r_v[7] + big_sigma1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + ROUND_K[i_cmd.round_idx] + r_w[0];
    assign t2 = big_sigma0(r_v[0])
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    assign nbytes_sat = (i_nbytes > 3'd4) ? 3'd4 : i_nbytes;
    assign byte_bits  = i_last ? {nbytes_sat, 3'b000} : 6'd32;

    always_ff @(posedge i_clk) begin
        if (i_cmd.push || i_cmd.round) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= shift_in;
        end
        if (i_cmd.load_vars) begin
            r_v <= r_h;
        end else if (i_cmd.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h    <= HASH_IV;
            r_bits <= '0;
        end else if (i_cmd.digest) begin
            r_h    <= HASH_IV;
            r_bits <= '0;
        end else begin
            if (i_cmd.update) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
            end
            if (i_cmd.take_input) begin
                r_bits <= r_bits + 64'(byte_bits);
            end
        end
    end

    // digest output register, drained one word per transaction
    assign out_take = r_out_valid && o_dig.ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.digest) begin
            r_out <= r_h;
        end else if (out_take) begin
            for (int i = 0; i < 7; i++) begin
                r_out[i] <= r_out[i + 1];
            end
            r_out[7] <= r_out[7];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_idx   <= '0;
        end else if (i_cmd.digest) begin
            r_out_valid <= 1'b1;
            r_out_idx   <= '0;
        end else if (out_take) begin
            r_out_idx <= 3'(r_out_idx + 3'd1);
            if (r_out_idx == 3'd7) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_dig.valid       = r_out_valid;
    assign o_dig.digest_word = r_out[0];
    assign o_dig.word_index  = r_out_idx;
    assign o_dig.final_word  = (r_out_idx == 3'd7);
    assign o_status.out_busy = r_out_valid;

endmodule

// ===== src/sha256_message_hasher_core.sv =====
// top level of the sha-256 message hasher
// depends on sha256mh_pkg, sha256mh_if, sha256mh_ctrl, sha256mh_dp
//
//   channel  | dir | payload                                   | transaction
//   ---------+-----+-------------------------------------------+-------------------------
//   i_msg    | in  | message_word, valid_bytes, end_of_message | one big-endian word
//   o_dig    | out | digest_word, word_index, final_word       | one of eight digest words
//
// a word is taken on each valid/ready handshake; every sixteenth word fills a block
// and is followed by the compression rounds and the chaining update, all run on
// the single shared round unit
// the last word adds padding pushes (one per cycle, paused during rounds, up to 18)
// and one or two compressions before the digest is copied to the output register
// reset is synchronous; the chaining hash returns to the initial value at once
// the output register drains one word per o_dig transaction; a new digest waits only
// while the previous one is still draining; input is held off during rounds, padding and digest handoff
module sha256_message_hasher_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sha256mh_in_if.sink   i_msg,
    sha256mh_out_if.source o_dig
);
    import sha256mh_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       in_ready;

    // controller: sequencing of input, padding, rounds and digest handoff
    sha256mh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_msg.valid),
        .i_last     (i_msg.end_of_message),
        .i_nbytes   (i_msg.valid_bytes),
        .o_in_ready (in_ready),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    assign i_msg.ready = in_ready;

    // datapath: block window, working variables, hash state, digest output
    sha256mh_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (status),
        .i_word   (i_msg.message_word),
        .i_nbytes (i_msg.valid_bytes),
        .i_last   (i_msg.end_of_message),
        .o_dig    (o_dig)
    );

endmodule

// ===== dv/sha256mh_tb_pkg.sv =====
`timescale 1ns / 1ps
// digest scoreboard for the sha-256 message hasher testbench: a bit-exact
// sha-256 predictor plus the queue of digest words still due
// no dependencies
package sha256mh_tb_pkg;

    localparam bit [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam bit [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct {
        bit [31:0] digest_word;
        bit [2:0]  word_index;
        bit        final_word;
    } digest_beat_t;

    class digest_scoreboard;
        bit [31:0]    chain [8];
        bit [31:0]    block_words [16];
        int unsigned  fill;
        bit [63:0]    bit_len;
        digest_beat_t digests_due [$];
        int unsigned  errors;

        function new();
            errors = 0;
            restart_message();
        endfunction

        function void restart_message();
            for (int j = 0; j < 8; j++) chain[j] = SHA_IV[j];
            fill    = 0;
            bit_len = 64'd0;
        endfunction

        function int unsigned pending();
            return digests_due.size();
        endfunction

        function bit [31:0] rotr(bit [31:0] x, int unsigned n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress_block();
            bit [31:0] sched [64];
            bit [31:0] v [8];
            bit [31:0] t1, t2, x, y;
            for (int i = 0; i < 16; i++) sched[i] = block_words[i];
            for (int i = 16; i < 64; i++) begin
                x = sched[i-15];
                y = sched[i-2];
                sched[i] = sched[i-16] + (rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3))
                         + sched[i-7] + (rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10));
            end
            for (int j = 0; j < 8; j++) v[j] = chain[j];
            for (int i = 0; i < 64; i++) begin
                t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + sched[i];
                t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + t2;
            end
            for (int j = 0; j < 8; j++) chain[j] += v[j];
        endfunction

        function void push_word(bit [31:0] w);
            block_words[fill] = w;
            fill++;
            if (fill == 16) begin
                compress_block();
                fill = 0;
            end
        endfunction

        // one accepted message word; a last word pads and queues the digest
        function void note_message_word(bit [31:0] w, bit [2:0] nb, bit last);
            int unsigned  n;
            bit [31:0]    keep;
            digest_beat_t beat;
            if (!last) begin
                push_word(w);
                bit_len += 64'd32;
                return;
            end
            n = (nb > 3'd4) ? 4 : int'(nb);
            bit_len += 64'(n * 8);
            if (n == 4) begin
                push_word(w);
                push_word(32'h8000_0000);
            end else begin
                keep = (n == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * n));
                push_word((w & keep) | (32'h80 << (24 - 8 * n)));
            end
            if (fill > 14) begin
                while (fill != 0) push_word(32'h0);
            end
            while (fill < 14) push_word(32'h0);
            push_word(bit_len[63:32]);
            push_word(bit_len[31:0]);
            for (int k = 0; k < 8; k++) begin
                beat.digest_word = chain[k];
                beat.word_index  = 3'(k);
                beat.final_word  = (k == 7);
                digests_due.push_back(beat);
            end
            restart_message();
        endfunction

        function void check_digest_word(logic [31:0] w, logic [2:0] idx, logic fin);
            digest_beat_t due;
            if (digests_due.size() == 0) begin
                $error("digest word %h at index %0d with no digest due", w, idx);
                errors++;
                return;
            end
            due = digests_due.pop_front();
            if (w !== due.digest_word) begin
                $error("digest_word: expected %h, actual %h", due.digest_word, w);
                errors++;
            end
            if (idx !== due.word_index) begin
                $error("word_index: expected %0d, actual %0d", due.word_index, idx);
                errors++;
            end
            if (fin !== due.final_word) begin
                $error("final_word: expected %0d, actual %0d", due.final_word, fin);
                errors++;
            end
        endfunction
    endclass

endpackage

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench of sha256_message_hasher_core: directed and random
// messages with random idle on both channels, digests checked word by word
// depends on sha256mh_if, sha256_message_hasher_core and sha256mh_tb_pkg
module tb_top;
    import sha256mh_tb_pkg::*;

    // total random message words to send after the directed part
    localparam int RANDOM_WORDS = 480;

    logic clk;
    logic rst_n;
    logic no_gaps;      // shuts off idling on both channels for a stretch
    int   words_sent;

    digest_scoreboard sb = new();

    sha256mh_in_if  msg_ch ();
    sha256mh_out_if dig_ch ();

    sha256_message_hasher_core uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_msg   (msg_ch),
        .o_dig   (dig_ch)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // mostly random words, with a fair share of all-zero and all-one words
    function automatic bit [31:0] pick_word();
        case ($urandom_range(9))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // one input transaction; valid stays up after acceptance so that the
    // next call can follow back to back, the caller lowers it otherwise
    task automatic send_word(input bit [31:0] w, input bit [2:0] nb, input bit last);
        while (!no_gaps && $urandom_range(99) < 29) begin
            msg_ch.valid <= 1'b0;
            @(posedge clk);
        end
        msg_ch.valid          <= 1'b1;
        msg_ch.message_word   <= w;
        msg_ch.valid_bytes    <= nb;
        msg_ch.end_of_message <= last;
        do @(posedge clk); while (msg_ch.ready !== 1'b1);
        sb.note_message_word(w, nb, last);
        words_sent++;
    endtask

    // body words carry junk byte counts, which the block must ignore
    task automatic send_message(input int body_words, input bit [2:0] last_nb);
        for (int i = 0; i < body_words; i++) begin
            send_word(pick_word(), 3'($urandom_range(7)), 1'b0);
        end
        send_word(pick_word(), last_nb, 1'b1);
    endtask

    // hold the sender off until every queued digest word has come out
    task automatic drain_digests();
        msg_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    // digest sink: check on every accepted transaction, then pick ready
    initial begin
        dig_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n === 1'b1 && dig_ch.valid === 1'b1 && dig_ch.ready === 1'b1) begin
                sb.check_digest_word(dig_ch.digest_word, dig_ch.word_index,
                                     dig_ch.final_word);
            end
            dig_ch.ready <= no_gaps || ($urandom_range(99) >= 29);
        end
    end

    // message source
    initial begin
        int body;
        int pick;
        rst_n                 <= 1'b0;
        no_gaps               <= 1'b0;
        msg_ch.valid          <= 1'b0;
        msg_ch.message_word   <= 32'h0;
        msg_ch.valid_bytes    <= 3'd0;
        msg_ch.end_of_message <= 1'b0;
        words_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // empty message: the last word carries no bytes at all
        send_word(32'hffff_ffff, 3'd0, 1'b1);
        // one-word messages with each short count, a full word, and counts
        // above four that saturate to a full word
        send_word(32'hffff_ffff, 3'd1, 1'b1);
        send_word(32'h0000_0000, 3'd2, 1'b1);
        send_word(32'ha5c3_0f69, 3'd3, 1'b1);
        send_word(32'hffff_ffff, 3'd4, 1'b1);
        send_word(32'h1234_5678, 3'd5, 1'b1);
        send_word(32'h8765_4321, 3'd7, 1'b1);
        // short count on a body word counts as four bytes
        send_word(32'hdead_beef, 3'd1, 1'b0);
        send_word(32'hffff_ffff, 3'd3, 1'b1);
        // full last word at position 13 forces the two-block padding
        for (int i = 0; i < 13; i++) begin
            send_word((i % 2) ? 32'hffff_ffff : 32'h0000_0000,
                      (i % 2) ? 3'd7 : 3'd0, 1'b0);
        end
        send_word(32'hffff_ffff, 3'd4, 1'b1);
        drain_digests();

        // random messages; lengths cluster around the padding boundary and
        // a few run over several blocks
        while (words_sent < RANDOM_WORDS + 23) begin
            no_gaps <= (words_sent >= 200 && words_sent < 300);
            pick = $urandom_range(99);
            if (pick < 55)      body = $urandom_range(8);
            else if (pick < 85) body = $urandom_range(17, 9);
            else                body = $urandom_range(60, 18);
            send_message(body, 3'($urandom_range(7)));
            if ($urandom_range(9) == 0) drain_digests();
        end

        // wait out the remaining digests, then a quiet window to catch extras
        drain_digests();
        repeat (200) @(posedge clk);
        if (sb.errors == 0) begin
            $display("sha256_message_hasher_core verification clean");
        end else begin
            $display("sha256_message_hasher_core verification failed");
        end
        $finish;
    end

    // safety net well beyond the slowest legal run
    initial begin
        #2000000;
        $display("sha256_message_hasher_core verification failed");
        $finish;
    end

endmodule
